>>> sv/noise_gate_envelope_smoothing_top_defines.svh
// Assertion macros for the noise gate block.
// Depends on nothing; used by the top level, which provides clk and rst_n.
`ifndef NOISE_GATE_ENVELOPE_SMOOTHING_TOP_DEFINES_SVH
`define NOISE_GATE_ENVELOPE_SMOOTHING_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NGE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define NGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/nge_pkg.sv
// Shared types and constants for the noise gate block.
// No dependencies; used by nge_ctrl, nge_datapath and the top level.
package nge_pkg;

    localparam int MAX_CHANNELS_DEF = 2;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 24;
    localparam int COEFF_W    = 16;
    localparam int PROD_W     = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [LEVEL_W-1:0] GAIN_ONE        = 24'h800000;
    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 24'd8389;
    localparam logic [COEFF_W-1:0] ENV_COEFF_RESET = 16'd272;
    localparam logic [COEFF_W-1:0] OPEN_COEFF_RESET  = 16'd679;
    localparam logic [COEFF_W-1:0] CLOSE_COEFF_RESET = 16'd14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD   = 2'd0,
        REG_ENV_COEFF   = 2'd1,
        REG_OPEN_COEFF  = 2'd2,
        REG_CLOSE_COEFF = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       channel;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gated_sample;
        logic                       channel_out;
    } out_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENV_MUL,
        S_ENV_UPD,
        S_GAIN_MUL,
        S_GAIN_UPD,
        S_OUT_MUL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic env_mul;
        logic env_upd;
        logic gain_mul;
        logic gain_upd;
        logic out_mul;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic ch_valid;
    } dp_stat_t;

endpackage

>>> sv/noise_gate_envelope_smoothing_top.sv
// Top level of the per-channel noise gate with envelope follower.
// Depends on nge_pkg, nge_ctrl, nge_datapath and the _defines.svh macros.
//
//   channel  handshake            payload               width
//   in       in_valid / in_ready  in_data  (in_beat_t)  17
//   out      out_valid/ out_ready out_data (out_beat_t) 17
//   cfg      cfg_we               cfg_index, cfg_data   2 + 24
//
// Between one accept and the next, a beat runs through six sequencer steps
// (envelope multiply and update, gain multiply and update, output multiply,
// output load) and then the idle state that accepts the next. All three products go
// through one shared 16x24 multiplier. A channel index not below MAX_CHANNELS
// skips from the envelope multiply straight to the output load.
// Reset is asynchronous, active low: envelopes clear, gains open fully,
// config registers take their defaults. A result waiting on out_ready
// stalls only the final load; no new input beat is taken until that load is done.
`include "noise_gate_envelope_smoothing_top_defines.svh"

module noise_gate_envelope_smoothing_top #(
    parameter int MAX_CHANNELS = nge_pkg::MAX_CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [nge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nge_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  nge_pkg::in_beat_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output nge_pkg::out_beat_t             out_data
);

    nge_pkg::dp_cmd_t  cmd;
    nge_pkg::dp_stat_t stat;

    // Sequencer: walks each beat through the multiplier steps
    nge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: registers, channel state, shared multiplier, output register
    nge_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

    // Drop ready right after an accepted beat: one beat in work at a time.
    `NGE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready held after accept")
    // Ready only falls because a beat was taken.
    `NGE_ASSERT_IMPLY(a_ready_fall_cause, $fell(in_ready), $past(in_valid), "ready fell without a beat")
    // A new result appears only while the sequencer is busy finishing a beat.
    `NGE_ASSERT_IMPLY(a_result_from_work, $rose(out_valid), $past(!in_ready), "result without work")

endmodule

>>> sv/nge_ctrl.sv
// Sequencer for the noise gate: steps one beat through the shared multiplier.
// Depends on nge_pkg (state_t, dp_cmd_t, dp_stat_t).
module nge_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  nge_pkg::dp_stat_t stat,
    output nge_pkg::dp_cmd_t  cmd
);

    nge_pkg::state_t state_reg;
    nge_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nge_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            nge_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = nge_pkg::S_ENV_MUL;
                end
            end
            nge_pkg::S_ENV_MUL:
            begin
                // Unknown channel: skip the state update, pass the sample.
                cmd.env_mul = 1'b1;
                state_next  = stat.ch_valid ? nge_pkg::S_ENV_UPD : nge_pkg::S_DONE;
            end
            nge_pkg::S_ENV_UPD:
            begin
                cmd.env_upd = 1'b1;
                state_next  = nge_pkg::S_GAIN_MUL;
            end
            nge_pkg::S_GAIN_MUL:
            begin
                cmd.gain_mul = 1'b1;
                state_next   = nge_pkg::S_GAIN_UPD;
            end
            nge_pkg::S_GAIN_UPD:
            begin
                cmd.gain_upd = 1'b1;
                state_next   = nge_pkg::S_OUT_MUL;
            end
            nge_pkg::S_OUT_MUL:
            begin
                cmd.out_mul = 1'b1;
                state_next  = nge_pkg::S_DONE;
            end
            nge_pkg::S_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = nge_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nge_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_ready  = (state_reg == nge_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> sv/nge_datapath.sv
// Datapath for the noise gate: config registers, per-channel state,
// one shared 16x24 multiplier and the output register. Depends on nge_pkg.
module nge_datapath #(
    parameter int MAX_CHANNELS = nge_pkg::MAX_CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nge_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nge_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  nge_pkg::in_beat_t                 in_data,
    input  nge_pkg::dp_cmd_t                  cmd,
    output nge_pkg::dp_stat_t                 stat,
    output nge_pkg::out_beat_t                out_data
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int LW   = nge_pkg::LEVEL_W;
    localparam int CW   = nge_pkg::COEFF_W;
    localparam int SW   = nge_pkg::SAMPLE_W;
    localparam int PW   = nge_pkg::PROD_W;

    logic [LW-1:0] thr_reg;
    logic [CW-1:0] env_coeff_reg;
    logic [CW-1:0] open_coeff_reg;
    logic [CW-1:0] close_coeff_reg;

    logic [LW-1:0] env_reg  [MAX_CHANNELS];
    logic [LW-1:0] gain_reg [MAX_CHANNELS];

    logic signed [SW-1:0] sample_reg;
    logic                 ch_reg;
    logic                 neg_reg;
    logic [SW-1:0]        mag_reg;
    logic [PW-1:0]        prod_reg;
    logic [PW-1:0]        prod_next;
    logic                 dir_reg;
    nge_pkg::out_beat_t   out_data_reg;

    logic [CH_W-1:0] ch_idx;
    logic [LW-1:0]   x_env;
    logic [LW-1:0]   x_gain;
    logic [LW-1:0]   rect;
    logic            env_dir;
    logic [LW-1:0]   env_gap;
    logic            gate_open;
    logic [LW-1:0]   gain_gap;
    logic [CW-1:0]   mul_a;
    logic [LW-1:0]   mul_b;
    logic [PW-1:0]   step_sum;
    logic [LW-1:0]   step;
    logic [LW-1:0]   x_env_next;
    logic [LW-1:0]   x_gain_next;
    logic [PW-1:0]   rnd_sum;
    logic [SW:0]     out_mag_raw;
    logic [SW-1:0]   out_mag;
    logic [SW-1:0]   result;
    logic [SW-1:0]   in_raw;
    logic [SW-1:0]   in_mag;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg         <= nge_pkg::THRESHOLD_RESET;
            env_coeff_reg   <= nge_pkg::ENV_COEFF_RESET;
            open_coeff_reg  <= nge_pkg::OPEN_COEFF_RESET;
            close_coeff_reg <= nge_pkg::CLOSE_COEFF_RESET;
        end
        else if (cfg_we)
        begin
            case (nge_pkg::cfg_reg_t'(cfg_index))
                nge_pkg::REG_THRESHOLD:   thr_reg         <= cfg_data;
                nge_pkg::REG_ENV_COEFF:   env_coeff_reg   <= cfg_data[CW-1:0];
                nge_pkg::REG_OPEN_COEFF:  open_coeff_reg  <= cfg_data[CW-1:0];
                nge_pkg::REG_CLOSE_COEFF: close_coeff_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    assign ch_idx         = CH_W'(ch_reg);
    assign stat.ch_valid  = (32'(ch_reg) < 32'(MAX_CHANNELS));

    assign x_env  = env_reg[ch_idx];
    assign x_gain = gain_reg[ch_idx];

    // Envelope gap toward the rectified sample
    assign rect    = {mag_reg, 8'd0};
    assign env_dir = (rect >= x_env);
    assign env_gap = env_dir ? (rect - x_env) : (x_env - rect);

    // Gate decision on the freshly updated envelope
    assign gate_open = (x_env >= thr_reg);
    assign gain_gap  = gate_open ? (nge_pkg::GAIN_ONE - x_gain) : x_gain;

    // Shared multiplier operand select
    always_comb
    begin
        if (cmd.env_mul)
        begin
            mul_a = env_coeff_reg;
            mul_b = env_gap;
        end
        else if (cmd.gain_mul)
        begin
            mul_a = gate_open ? open_coeff_reg : close_coeff_reg;
            mul_b = gain_gap;
        end
        else
        begin
            mul_a = mag_reg;
            mul_b = x_gain;
        end
    end

    assign prod_next = {{(PW-CW){1'b0}}, mul_a} * {{(PW-LW){1'b0}}, mul_b};

    // Rounded smoothing step, never past the target
    assign step_sum    = prod_reg + PW'(32768);
    assign step        = step_sum[PW-1:16];
    assign x_env_next  = dir_reg ? (x_env + step) : (x_env - step);
    assign x_gain_next = dir_reg ? (x_gain + step) : (x_gain - step);

    // Output scaling: round half away from zero, then saturate
    assign rnd_sum     = prod_reg + PW'(4194304);
    assign out_mag_raw = rnd_sum[PW-1:23];

    always_comb
    begin
        if (neg_reg)
        begin
            out_mag = (out_mag_raw > 17'd32768) ? 16'd32768 : out_mag_raw[SW-1:0];
            result  = 16'd0 - out_mag;
        end
        else
        begin
            out_mag = (out_mag_raw > 17'd32767) ? 16'd32767 : out_mag_raw[SW-1:0];
            result  = out_mag;
        end
    end

    assign in_raw = in_data.sample;
    assign in_mag = in_raw[SW-1] ? (16'd0 - in_raw) : in_raw;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg <= in_data.sample;
            ch_reg     <= in_data.channel;
            neg_reg    <= in_raw[SW-1];
            mag_reg    <= in_mag;
        end
        if (cmd.env_mul || cmd.gain_mul || cmd.out_mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.env_mul)
        begin
            dir_reg <= env_dir;
        end
        else if (cmd.gain_mul)
        begin
            dir_reg <= gate_open;
        end
        if (cmd.out_load)
        begin
            out_data_reg.gated_sample <= stat.ch_valid ? $signed(result) : sample_reg;
            out_data_reg.channel_out  <= ch_reg;
        end
    end

    // Per-channel envelope and gain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                env_reg[c]  <= '0;
                gain_reg[c] <= nge_pkg::GAIN_ONE;
            end
        end
        else
        begin
            if (cmd.env_upd)
            begin
                env_reg[ch_idx] <= x_env_next;
            end
            if (cmd.gain_upd)
            begin
                gain_reg[ch_idx] <= x_gain_next;
            end
        end
    end

    assign out_data = out_data_reg;

endmodule

>>> tb/sv/nge_tb_pkg.sv
// Bit-accurate gain predictor and result checker for the noise gate testbench.
// Depends on nge_pkg for the beat types, widths and register reset values.
package nge_tb_pkg;

    import nge_pkg::*;

    class gate_checker;

        logic [LEVEL_W-1:0] threshold;
        logic [COEFF_W-1:0] env_k;
        logic [COEFF_W-1:0] open_k;
        logic [COEFF_W-1:0] close_k;
        logic [LEVEL_W-1:0] envelope [MAX_CHANNELS_DEF];
        logic [LEVEL_W-1:0] gain [MAX_CHANNELS_DEF];
        out_beat_t          expected_gated [$];
        int                 faults;

        function new();
            threshold = THRESHOLD_RESET;
            env_k     = ENV_COEFF_RESET;
            open_k    = OPEN_COEFF_RESET;
            close_k   = CLOSE_COEFF_RESET;
            for (int c = 0; c < MAX_CHANNELS_DEF; c++)
            begin
                envelope[c] = '0;
                gain[c]     = GAIN_ONE;
            end
            faults = 0;
        endfunction

        function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
            case (r)
                REG_THRESHOLD:   threshold = v[LEVEL_W-1:0];
                REG_ENV_COEFF:   env_k     = v[COEFF_W-1:0];
                REG_OPEN_COEFF:  open_k    = v[COEFF_W-1:0];
                REG_CLOSE_COEFF: close_k   = v[COEFF_W-1:0];
                default: ;
            endcase
        endfunction

        // Step x toward aim by the rounded fraction k/65536 of the gap.
        function logic [LEVEL_W-1:0] follow(logic [LEVEL_W-1:0] x, logic [LEVEL_W-1:0] aim,
                                            logic [COEFF_W-1:0] k);
            logic [47:0] span;
            logic [47:0] delta;
            if (aim >= x)
            begin
                span  = 48'(aim - x);
                delta = (48'(k) * span + 48'd32768) >> 16;
                return x + delta[LEVEL_W-1:0];
            end
            span  = 48'(x - aim);
            delta = (48'(k) * span + 48'd32768) >> 16;
            return x - delta[LEVEL_W-1:0];
        endfunction

        function void note_sample(in_beat_t b);
            logic               neg;
            logic [16:0]        mag;
            logic [16:0]        omag;
            logic [47:0]        prod;
            logic [LEVEL_W-1:0] aim;
            logic [COEFF_W-1:0] k;
            int                 ch;
            out_beat_t          want;
            neg  = b.sample[SAMPLE_W-1];
            mag  = neg ? 17'h10000 - {1'b0, b.sample} : {1'b0, b.sample};
            ch   = b.channel;
            envelope[ch] = follow(envelope[ch], 24'(mag) << 8, env_k);
            aim  = (envelope[ch] >= threshold) ? GAIN_ONE : '0;
            k    = (aim > gain[ch]) ? open_k : close_k;
            gain[ch] = follow(gain[ch], aim, k);
            prod = (48'(mag) * 48'(gain[ch]) + 48'd4194304) >> 23;
            if (neg)
            begin
                omag = (prod > 48'd32768) ? 17'd32768 : prod[16:0];
                want.gated_sample = 16'(17'h10000 - omag);
            end
            else
            begin
                omag = (prod > 48'd32767) ? 17'd32767 : prod[16:0];
                want.gated_sample = omag[15:0];
            end
            want.channel_out = b.channel;
            expected_gated.push_back(want);
        endfunction

        function void report(string what);
            faults++;
            if (faults <= 10)
                $display("mismatch %0d: %s", faults, what);
        endfunction

        function void check_gated(out_beat_t got);
            out_beat_t want;
            if (expected_gated.size() == 0)
            begin
                report($sformatf("result with nothing pending: gated %0d, channel %0d",
                                 got.gated_sample, got.channel_out));
                return;
            end
            want = expected_gated.pop_front();
            if (got.gated_sample !== want.gated_sample)
                report($sformatf("gated_sample expected %0d, got %0d",
                                 want.gated_sample, got.gated_sample));
            if (got.channel_out !== want.channel_out)
                report($sformatf("channel_out expected %0d, got %0d",
                                 want.channel_out, got.channel_out));
        endfunction

        function int pending();
            return expected_gated.size();
        endfunction

        function void close_out();
            out_beat_t lost;
            while (expected_gated.size() != 0)
            begin
                lost = expected_gated.pop_front();
                report($sformatf("missing result: gated %0d, channel %0d",
                                 lost.gated_sample, lost.channel_out));
            end
        endfunction

    endclass

endpackage

>>> tb/sv/tb_top.sv
// Testbench top for the noise gate: drives sample beats and register writes,
// predicts every gated result and checks it. Depends on nge_pkg, nge_tb_pkg
// and the noise_gate_envelope_smoothing_top RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import nge_pkg::*;
    import nge_tb_pkg::*;

    // Sample styles for the random stream.
    localparam int STY_QUIET  = 0;
    localparam int STY_LOUD   = 1;
    localparam int STY_CORNER = 2;
    localparam int STY_ANY    = 3;

    // Receiver stall patterns.
    localparam int RX_OPEN = 0;
    localparam int RX_COIN = 1;
    localparam int RX_HOLD = 2;
    localparam int RX_COMB = 3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_beat_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_beat_t             out_data;

    gate_checker gate_chk;

    int unsigned rx_mode     = RX_OPEN;
    int unsigned rx_seg_left = 0;
    int unsigned rx_hold     = 0;
    int unsigned rx_tick     = 0;

    noise_gate_envelope_smoothing_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Give up well past the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

    // Sample both handshakes at the rising edge, before the block's own
    // updates land: note each accepted sample beat, check each result beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                gate_chk.note_sample(in_data);
            if (out_valid && out_ready)
                gate_chk.check_gated(out_data);
        end
    end

    // Receiver: switch between stall patterns in segments of random length.
    // Always ready, coin flips, long holds, and a fixed periodic comb.
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_seg_left == 0)
        begin
            rx_mode     <= $urandom_range(RX_OPEN, RX_COMB);
            rx_seg_left <= $urandom_range(20, 200);
        end
        else
        begin
            rx_seg_left <= rx_seg_left - 1;
        end
        case (rx_mode)
            RX_COIN: out_ready <= ($urandom_range(0, 3) != 0);
            RX_HOLD:
            begin
                if (rx_hold > 0)
                begin
                    out_ready <= 1'b0;
                    rx_hold   <= rx_hold - 1;
                end
                else
                begin
                    out_ready <= 1'b1;
                    rx_hold   <= $urandom_range(0, 30);
                end
            end
            RX_COMB: out_ready <= ((rx_tick % 17) < 3);
            default: out_ready <= 1'b1;
        endcase
    end

    function automatic in_beat_t beat(logic signed [SAMPLE_W-1:0] s, logic ch);
        in_beat_t b;
        b.sample  = s;
        b.channel = ch;
        return b;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int style);
        logic [SAMPLE_W-1:0] mag;
        logic [SAMPLE_W-1:0] corner [5];
        corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
        mag    = '0;
        case (style)
            STY_QUIET: mag = 16'($urandom_range(0, (1 << $urandom_range(0, 8)) - 1));
            STY_LOUD:
            begin
                if ($urandom_range(0, 15) == 0)
                    return 16'h8000;
                mag = 16'($urandom_range(8192, 32767));
            end
            STY_CORNER: return corner[$urandom_range(0, 4)];
            default: return 16'($urandom());
        endcase
        return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return GAIN_ONE;
            2: return 24'hFFFFFF;
            5: return 24'($urandom());
            default: return 24'($urandom_range(0, 24'h100000));
        endcase
    endfunction

    // Coefficients are 16 bits; now and then put junk above them.
    function automatic logic [CFG_DATA_W-1:0] pick_coeff();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = 24'd65535;
            2: v = 24'($urandom_range(1, 64));
            5: v = 24'($urandom_range(0, 65535));
            default: v = 24'($urandom_range(1000, 65535));
        endcase
        if ($urandom_range(0, 3) == 0)
            v[23:16] = 8'($urandom());
        return v;
    endfunction

    // Present one beat at the falling edge and hold it until accepted.
    // Returns at the falling edge after the accepting rising edge.
    task automatic send_beat(input in_beat_t b);
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid after the last beat of a directed group.
    task automatic send_group(input in_beat_t beats [$]);
        foreach (beats[i])
            send_beat(beats[i]);
        in_valid <= 1'b0;
    endtask

    // Wait for every pending result, then an idle margin.
    task automatic settle();
        while (gate_chk.pending() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic put_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        gate_chk.write_reg(r, v);
        @(negedge clk);
    endtask

    // Write all four registers back to back; call only with the block idle.
    task automatic put_settings(input logic [CFG_DATA_W-1:0] th, input logic [CFG_DATA_W-1:0] ek,
                                input logic [CFG_DATA_W-1:0] ok, input logic [CFG_DATA_W-1:0] ck);
        put_reg(REG_THRESHOLD, th);
        put_reg(REG_ENV_COEFF, ek);
        put_reg(REG_OPEN_COEFF, ok);
        put_reg(REG_CLOSE_COEFF, ck);
        cfg_we <= 1'b0;
    endtask

    // Random stream: bursts of one loudness style, so envelopes climb past or
    // sink below the threshold and the gain has time to open and close.
    task automatic run_stream(input int count);
        int  left;
        int  burst;
        int  gap;
        int  style;
        int  ch_mode;
        int  roll;
        bit  ch_first;
        bit  gappy;
        bit  ch;
        gappy = ($urandom_range(0, 2) != 0);
        left  = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            roll = $urandom_range(0, 19);
            if (roll < 7)
                style = STY_LOUD;
            else if (roll < 14)
                style = STY_QUIET;
            else if (roll < 18)
                style = STY_ANY;
            else
                style = STY_CORNER;
            ch_mode  = $urandom_range(0, 2);
            ch_first = $urandom_range(0, 1);
            for (int k = 0; k < burst; k++)
            begin
                if (ch_mode == 0)
                    ch = ch_first;
                else if (ch_mode == 1)
                    ch = ch_first ^ k[0];
                else
                    ch = $urandom_range(0, 1);
                send_beat(beat(pick_sample(style), ch));
            end
            left -= burst;
            gap = gappy ? $urandom_range(0, 12) : 0;
            // Hold valid across a zero gap; drop it otherwise and at the end.
            if (gap > 0 || left == 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        int drain;
        gate_chk = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: full-scale and unit samples on both channels, zero on channel 0.
        send_group('{beat(16'sh7FFF, 1'b0), beat(16'sh8000, 1'b1), beat(16'sh0000, 1'b0),
                     beat(16'shFFFF, 1'b1), beat(16'sh0001, 1'b0), beat(16'sh8000, 1'b0)});
        settle();

        // Zero threshold: the target stays open whatever the envelope does.
        put_settings(24'd0, 24'd65535, 24'd65535, 24'd65535);
        send_group('{beat(16'sh8000, 1'b0), beat(16'sh7FFF, 1'b1), beat(16'sh0000, 1'b0),
                     beat(16'shFFFF, 1'b1), beat(16'sh4000, 1'b0)});
        settle();

        // Threshold above unity: the envelope can never reach it, gate shuts fast.
        put_settings(24'hFFFFFF, 24'd65535, 24'd65535, 24'd65535);
        send_group('{beat(16'sh7FFF, 1'b0), beat(16'sh8000, 1'b1), beat(16'sh7FFF, 1'b0),
                     beat(16'sh8000, 1'b1), beat(16'sd100, 1'b0)});
        settle();

        // Zero coefficients: envelope and gain hold still.
        put_settings(24'd0, 24'd0, 24'd0, 24'd0);
        send_group('{beat(16'sh7FFF, 1'b0), beat(16'sh8000, 1'b1), beat(16'shFFFF, 1'b0),
                     beat(16'sh0001, 1'b1)});
        settle();

        // Threshold exactly at unity: only a full-scale negative sample reaches it.
        put_settings(GAIN_ONE, 24'd65535, 24'd65535, 24'd32768);
        send_group('{beat(16'sh8000, 1'b0), beat(16'sh7FFF, 1'b0), beat(16'sh8000, 1'b0),
                     beat(16'sh0000, 1'b1)});
        settle();

        // Random phases: reset settings first, then a fresh random setting each time.
        for (int p = 0; p < 10; p++)
        begin
            if (p == 0)
                put_settings(THRESHOLD_RESET, CFG_DATA_W'(ENV_COEFF_RESET),
                             CFG_DATA_W'(OPEN_COEFF_RESET), CFG_DATA_W'(CLOSE_COEFF_RESET));
            else
                put_settings(pick_threshold(), pick_coeff(), pick_coeff(), pick_coeff());
            run_stream(90);
            settle();
        end

        // Drain with a bound, then a short quiet tail to catch stray results.
        drain = 0;
        while (gate_chk.pending() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        gate_chk.close_out();
        if (gate_chk.faults == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
